[sv/pem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_pkg: shared types and constants for the polynomial evaluator
// Field widths, beat layout, request and register codes, sequencer states.
// ----------------------------------------------------------------------------
package pem_pkg;

  // Payload field widths
  localparam int IDX_W   = 6;
  localparam int COEF_W  = 32;
  localparam int POINT_W = 16;
  localparam int VALUE_W = 16;
  localparam int MODR_W  = 16;
  localparam int DEG_W   = 6;

  // Beat layout
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  // Request kinds carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEGREE  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XRED,
    ST_COEF,
    ST_CRED,
    ST_PRED,
    ST_ACC,
    ST_DONE
  } pem_state_t;

endpackage

[sv/pem_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/poly_eval_mod_p_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_eval_mod_p_top: polynomial evaluation modulo p by Horner's rule
// Coefficient store plus a bit-serial modular reduction sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  beats carry a request. tuser = 0 loads coef_value at coef_index
//         (indexes at or above COEF_DEPTH are dropped); tuser = 1 evaluates
//         the polynomial of coefficients 0..degree at point, mod modulus.
//   out_* carries one beat per evaluate request: the value in 0..p-1.
//   cfg_* writes modulus (index 0) and degree (index 1); write only when idle.
// Sequence:
//   A load is written to the store as its beat is accepted. An evaluate
//   reduces the point, then for each coefficient from index degree down
//   to 0 reduces the coefficient and the product and accumulates; a zero
//   modulus goes straight to the result. The single compare-subtract unit
//   reduces one bit per cycle: 32 bits per coefficient, 2*MOD_WIDTH bits per
//   product, plus a multiply step and an accumulate step.
//   in_tready is low while an evaluation runs.
// Reset: modulus = 1, degree = 0, channels empty; the store is undefined.
// Stall: a held result sits in the output register; loads are still taken,
//   and a further evaluation waits in its last state until the slot is free.
// ----------------------------------------------------------------------------
module poly_eval_mod_p_top #(
  parameter int COEF_DEPTH = 64,
  parameter int MOD_WIDTH  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: coef_index[5:0], coef_value[37:6], point[53:38], zero[55:54]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pem_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: req_type[0]
  input  logic [pem_pkg::IN_TUSER_W-1:0]     in_tuser,
  // out_tdata: value[15:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pem_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [pem_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pem_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import pem_pkg::*;

  localparam int MW = MOD_WIDTH;
  localparam int AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int SW = (2 * MOD_WIDTH > COEF_W) ? 2 * MOD_WIDTH : COEF_W;
  localparam int CW = $clog2(SW + 1);

  // Input field split
  logic                req_type;
  logic [IDX_W-1:0]    coef_index;
  logic [COEF_W-1:0]   coef_value;
  logic [POINT_W-1:0]  point;

  assign req_type   = in_tuser[0];
  assign coef_index = in_tdata[5:0];
  assign coef_value = in_tdata[37:6];
  assign point      = in_tdata[53:38];

  // Registers
  pem_state_t          state_r, state_nxt;
  logic [MW-1:0]       p_r, p_nxt;
  logic [MW-1:0]       x_r, x_nxt;
  logic [MW-1:0]       acc_r, acc_nxt;
  logic [MW-1:0]       rem_r, rem_nxt;
  logic [MW-1:0]       cres_r, cres_nxt;
  logic                neg_r, neg_nxt;
  logic [SW-1:0]       sh_r, sh_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [2*MW-1:0]     prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [MODR_W-1:0]   modulus_r;
  logic [DEG_W-1:0]    degree_r;

  // Store ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [COEF_W-1:0]   ram_rdata;

  // Misc combinational
  logic [MW-1:0]       p_in;
  logic [AW-1:0]       top_idx;
  logic [COEF_W-1:0]   mag;
  logic [MW:0]         s_acc;
  logic [MW:0]         u_in;
  logic [MW:0]         u_out;
  logic                step_last;

  // Coefficient store, written straight from an accepted load beat
  assign ram_we    = in_tvalid && in_tready && (req_type == REQ_LOAD) &&
                     (32'(coef_index) < COEF_DEPTH);
  assign ram_waddr = AW'(coef_index);

  pem_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (coef_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Evaluation set-up: live modulus and saturated top index
  assign p_in = MW'(modulus_r);

  always_comb begin
    if (32'(degree_r) > COEF_DEPTH - 1) begin
      top_idx = AW'(COEF_DEPTH - 1);
    end else begin
      top_idx = AW'(degree_r);
    end
  end

  // Coefficient magnitude; the most negative value maps onto itself
  assign mag = ram_rdata[COEF_W-1] ? (~ram_rdata + 32'd1) : ram_rdata;

  // Accumulate: product residue plus signed coefficient residue, below 2p
  assign s_acc = {1'b0, rem_r} +
                 (neg_r ? ({1'b0, p_r} - {1'b0, cres_r}) : {1'b0, cres_r});

  // Shared compare-subtract unit
  always_comb begin
    if (state_r == ST_ACC) begin
      u_in = s_acc;
    end else begin
      u_in = {rem_r, sh_r[SW-1]};
    end
    u_out = (u_in >= {1'b0, p_r}) ? (u_in - {1'b0, p_r}) : u_in;
  end

  assign step_last = (cnt_r == CW'(1));

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    cres_nxt      = cres_r;
    neg_nxt       = neg_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;
    in_tready     = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (req_type == REQ_EVAL)) begin
          p_nxt   = p_in;
          acc_nxt = '0;
          rem_nxt = '0;
          idx_nxt = top_idx;
          sh_nxt  = SW'(point) << (SW - POINT_W);
          cnt_nxt = CW'(POINT_W);
          if (p_in == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_XRED;
          end
        end
      end

      // reduce the point, then fetch the top coefficient
      ST_XRED: begin
        rem_nxt = u_out[MW-1:0];
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (step_last) begin
          x_nxt     = u_out[MW-1:0];
          ram_re    = 1'b1;
          state_nxt = ST_COEF;
        end
      end

      // coefficient arrives; multiply acc by x alongside
      ST_COEF: begin
        neg_nxt   = ram_rdata[COEF_W-1];
        sh_nxt    = SW'(mag) << (SW - COEF_W);
        cnt_nxt   = CW'(COEF_W);
        rem_nxt   = '0;
        prod_nxt  = {{MW{1'b0}}, acc_r} * {{MW{1'b0}}, x_r};
        state_nxt = ST_CRED;
      end

      // reduce the coefficient magnitude
      ST_CRED: begin
        rem_nxt = u_out[MW-1:0];
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (step_last) begin
          cres_nxt  = u_out[MW-1:0];
          rem_nxt   = '0;
          sh_nxt    = SW'(prod_r) << (SW - 2 * MW);
          cnt_nxt   = CW'(2 * MW);
          state_nxt = ST_PRED;
        end
      end

      // reduce the product
      ST_PRED: begin
        rem_nxt = u_out[MW-1:0];
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (step_last) begin
          state_nxt = ST_ACC;
        end
      end

      // fold in the coefficient residue; next coefficient or finish
      ST_ACC: begin
        acc_nxt = u_out[MW-1:0];
        if (idx_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_r - AW'(1);
          state_nxt = ST_COEF;
        end
      end

      // hand over once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = VALUE_W'(acc_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    x_r         <= x_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    cres_r      <= cres_nxt;
    neg_r       <= neg_nxt;
    sh_r        <= sh_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    prod_r      <= prod_nxt;
    out_value_r <= out_value_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODR_W'(1);
      degree_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODULUS: modulus_r <= cfg_wdata;
        REG_DEGREE:  degree_r  <= cfg_wdata[DEG_W-1:0];
        default:     modulus_r <= modulus_r;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;

`ifndef NO_ASSERTIONS
  // accumulator stays a residue throughout the Horner loop
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COEF || state_r == ST_CRED || state_r == ST_PRED ||
     state_r == ST_ACC) |-> (acc_r < p_r))
    else $error("accumulator not below modulus");

  // both residues are reduced before they are combined
  a_acc_inputs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (rem_r < p_r) && (cres_r < p_r))
    else $error("unreduced operand at accumulate");

  // an accepted evaluate request makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == REQ_EVAL)) |=> !in_tready)
    else $error("input taken during evaluation");
`endif

endmodule
